@@ hw/rtl/stlex_pkg.sv @@
package stlex_pkg;

  // Word store geometry.
  localparam int MAX_WORD_LEN = 32;
  localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
  localparam int ADDR_W       = $clog2(MAX_WORD_LEN);

  // Integer literals saturate at the largest 31-bit value.
  localparam int              NUM_W     = 31;
  localparam logic [NUM_W-1:0] NUM_LIMIT = {NUM_W{1'b1}};

  // Reserved words, first character in the top byte.
  localparam logic [23:0] KW_VAR = "var";
  localparam logic [23:0] KW_I64 = "i64";
  localparam logic [23:0] KW_I32 = "i32";
  localparam logic [23:0] KW_I16 = "i16";
  localparam logic [15:0] KW_I8  = "i8";

  localparam logic [NUM_W-1:0] TYPE_I64 = NUM_W'(0);
  localparam logic [NUM_W-1:0] TYPE_I32 = NUM_W'(1);
  localparam logic [NUM_W-1:0] TYPE_I16 = NUM_W'(2);
  localparam logic [NUM_W-1:0] TYPE_I8  = NUM_W'(3);

  localparam logic [7:0] CH_EQ  = "=";
  localparam logic [7:0] CH_AND = "&";
  localparam logic [7:0] CH_OR  = "|";

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2,
    MODE_OP   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_SYM   = 3'd0,
    KIND_OP    = 3'd1,
    KIND_VAR   = 3'd2,
    KIND_TYPE  = 3'd3,
    KIND_INT   = 3'd4,
    KIND_IDENT = 3'd5,
    KIND_ERR   = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       first;
    logic [7:0]       second;
    logic [NUM_W-1:0] number;
    logic             done;
  } result_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;       // capture the requested byte
    logic cont;       // byte continues the pending token
    logic flush_tok;  // emit the pending single token and clear
    logic clear;      // drop the pending state without output
    logic rd0;        // start reading a word from its first character
    logic word_emit;  // emit one identifier character
    logic start;      // open a new token with the captured byte
    logic finish;     // release the last result of the request
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    mode_e mode;
    logic  cont;       // captured byte extends the pending token
    logic  eos;        // captured byte ends the source
    logic  word_run;   // pending word flushes as a run of characters
    logic  word_none;  // pending word flushes to nothing
    logic  word_last;  // current character is the word's last
    logic  can_emit;   // result staging can take a result this cycle
  } status_t;

  function automatic logic is_sep(input logic [7:0] c);
    return c inside {8'h20, 8'h0A, 8'h09};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_wordch(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == 8'h5F);
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return c inside {"{", "}", ":", ";", "#", "(", ")", "[", "]"};
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c inside {"+", "-", "*", "/", "%", "<", ">", "^", "!", "=",
                     "~", "|", "&", ",", ".", "?"};
  endfunction

  function automatic logic takes_eq(input logic [7:0] c);
    return c inside {"+", "-", "*", "/", "%", "!", "=", "<", ">"};
  endfunction

endpackage

@@ hw/rtl/source_text_lexer.sv @@
// Byte-serial lexer. Each request carries one source byte and an end-of-source
// flag; the block answers with zero or more token results, the last result of
// a request marked by step_done_o, the last result of a token by
// token_done_o. A token is reported only once the following byte shows that
// it has ended, or when end-of-source flushes it. Identifiers come out as a
// run of one result per character, read back from a 32-entry word store;
// var and the type names i64, i32, i16 and i8 come out as single results.
// Unknown bytes and over-long identifiers yield error results. A request
// that continues the pending token passes through capture, evaluate and
// close. A request that ends the pending token or stands alone passes
// through capture, evaluate, flush, open and close; a single-result token
// is emitted inside the flush or open phase. Flushing a pending identifier
// as a run adds a first read from the word store and then emits the
// characters one at a time, each read in turn, since the store has a single
// read port. End of source adds one more flush phase, which runs the same
// way. The sequencer walks these phases one at a time, and every phase that
// produces a result waits while the result staging is full, so a slow
// receiver stretches a request. A new request is taken only after every
// result of the previous one has been staged, while the last of them may
// still wait in the output register.
module source_text_lexer import stlex_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       source_byte_i,
  input  logic             end_of_source_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       token_kind_o,
  output logic [7:0]       first_char_o,
  output logic [7:0]       second_char_o,
  output logic [NUM_W-1:0] number_o,
  output logic             token_done_o,
  output logic             step_done_o
);

  cmd_t    cmd;
  status_t st;

  // The sequencer decides which phase of a request runs in each cycle.
  stlex_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  // The datapath holds the scan state, the word store and the result staging.
  stlex_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .source_byte_i  (source_byte_i),
    .end_of_source_i(end_of_source_i),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_valid_o    (out_valid_o),
    .token_kind_o   (token_kind_o),
    .first_char_o   (first_char_o),
    .second_char_o  (second_char_o),
    .number_o       (number_o),
    .token_done_o   (token_done_o),
    .step_done_o    (step_done_o)
  );

endmodule

@@ hw/rtl/stlex_ram.sv @@
module stlex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/stlex_dp.sv @@
module stlex_dp import stlex_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       source_byte_i,
  input  logic             end_of_source_i,
  input  logic             out_ready_i,
  input  cmd_t             cmd_i,
  output status_t          st_o,
  output logic             out_valid_o,
  output logic [2:0]       token_kind_o,
  output logic [7:0]       first_char_o,
  output logic [7:0]       second_char_o,
  output logic [NUM_W-1:0] number_o,
  output logic             token_done_o,
  output logic             step_done_o
);

  function automatic result_t mk_res(input kind_e k, input logic [7:0] c1,
                                     input logic [7:0] c2,
                                     input logic [NUM_W-1:0] n, input logic d);
    result_t r;
    r.kind   = k;
    r.first  = c1;
    r.second = c2;
    r.number = n;
    r.done   = d;
    return r;
  endfunction

  logic [7:0]       byte_q;
  logic             eos_q;
  mode_e            mode_q, mode_d;
  logic [NUM_W-1:0] acc_q, acc_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       pend_q, pend_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [7:0]       shadow_q [3];

  logic             hold_valid_q, hold_valid_d;
  result_t          hold_res_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q;
  logic             out_step_q;

  logic             emit;
  result_t          emit_res;
  logic             load_out;
  logic             can_emit;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        rdata;

  logic [NUM_W+3:0]  acc_wide;
  logic              op_pair;
  logic              cont;
  logic              kw_var, kw_i64, kw_i32, kw_i16, kw_i8, kw_hit;
  logic [23:0]       shadow3;
  logic              word_last;
  logic              do_clear;

  stlex_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WORD_LEN)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(byte_q),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Classification of the captured byte against the pending token.
  assign op_pair = (takes_eq(pend_q) && (byte_q == CH_EQ)) ||
                   (((pend_q == CH_AND) || (pend_q == CH_OR)) && (byte_q == pend_q));
  assign cont = ((mode_q == MODE_OP) && op_pair) ||
                ((mode_q == MODE_NUM) && is_digit(byte_q)) ||
                ((mode_q == MODE_WORD) && is_wordch(byte_q));

  assign shadow3 = {shadow_q[0], shadow_q[1], shadow_q[2]};
  assign kw_var  = (len_q == LEN_W'(3)) && (shadow3 == KW_VAR);
  assign kw_i64  = (len_q == LEN_W'(3)) && (shadow3 == KW_I64);
  assign kw_i32  = (len_q == LEN_W'(3)) && (shadow3 == KW_I32);
  assign kw_i16  = (len_q == LEN_W'(3)) && (shadow3 == KW_I16);
  assign kw_i8   = (len_q == LEN_W'(2)) && ({shadow_q[0], shadow_q[1]} == KW_I8);
  assign kw_hit  = kw_var || kw_i64 || kw_i32 || kw_i16 || kw_i8;

  assign word_last = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);

  // acc * 10 + digit; the low nibble of an ASCII digit is its value.
  assign acc_wide = ({4'b0000, acc_q} << 3) + ({4'b0000, acc_q} << 1) +
                    (NUM_W + 4)'(byte_q[3:0]);

  assign can_emit = !hold_valid_q || !out_valid_q || out_ready_i;

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    len_d    = len_q;
    pend_d   = pend_q;
    idx_d    = idx_q;
    emit     = 1'b0;
    emit_res = mk_res(KIND_SYM, 8'h00, 8'h00, '0, 1'b1);
    we       = 1'b0;
    waddr    = len_q[ADDR_W-1:0];
    re       = 1'b0;
    raddr    = idx_q + ADDR_W'(1);
    do_clear = 1'b0;

    if (cmd_i.cont) begin
      case (mode_q)
        MODE_OP: begin
          emit     = 1'b1;
          emit_res = mk_res(KIND_OP, pend_q, byte_q, '0, 1'b1);
          mode_d   = MODE_IDLE;
          pend_d   = 8'h00;
        end
        MODE_NUM: begin
          acc_d = (acc_wide > (NUM_W + 4)'(NUM_LIMIT)) ? NUM_LIMIT : acc_wide[NUM_W-1:0];
        end
        MODE_WORD: begin
          if (len_q == '0) begin
            // Tail of an over-long word is swallowed.
          end else if (len_q < LEN_W'(MAX_WORD_LEN)) begin
            we    = 1'b1;
            len_d = len_q + LEN_W'(1);
          end else begin
            emit     = 1'b1;
            emit_res = mk_res(KIND_ERR, byte_q, 8'h00, '0, 1'b1);
            len_d    = '0;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.flush_tok) begin
      emit     = 1'b1;
      do_clear = 1'b1;
      case (mode_q)
        MODE_NUM: emit_res = mk_res(KIND_INT, 8'h00, 8'h00, acc_q, 1'b1);
        MODE_OP:  emit_res = mk_res(KIND_OP, pend_q, 8'h00, '0, 1'b1);
        default: begin
          if (kw_var) begin
            emit_res = mk_res(KIND_VAR, 8'h00, 8'h00, '0, 1'b1);
          end else if (kw_i64) begin
            emit_res = mk_res(KIND_TYPE, 8'h00, 8'h00, TYPE_I64, 1'b1);
          end else if (kw_i32) begin
            emit_res = mk_res(KIND_TYPE, 8'h00, 8'h00, TYPE_I32, 1'b1);
          end else if (kw_i16) begin
            emit_res = mk_res(KIND_TYPE, 8'h00, 8'h00, TYPE_I16, 1'b1);
          end else begin
            emit_res = mk_res(KIND_TYPE, 8'h00, 8'h00, TYPE_I8, 1'b1);
          end
        end
      endcase
    end

    if (cmd_i.clear) begin
      do_clear = 1'b1;
    end

    if (cmd_i.rd0) begin
      re    = 1'b1;
      raddr = '0;
      idx_d = '0;
    end

    if (cmd_i.word_emit) begin
      emit     = 1'b1;
      emit_res = mk_res(KIND_IDENT, rdata, 8'h00, '0, word_last);
      if (word_last) begin
        do_clear = 1'b1;
      end else begin
        re    = 1'b1;
        idx_d = idx_q + ADDR_W'(1);
      end
    end

    if (cmd_i.start) begin
      if (is_sep(byte_q)) begin
        // Separators only end tokens.
      end else if (is_sym(byte_q)) begin
        emit     = 1'b1;
        emit_res = mk_res(KIND_SYM, byte_q, 8'h00, '0, 1'b1);
      end else if (is_op(byte_q)) begin
        mode_d = MODE_OP;
        pend_d = byte_q;
      end else if (is_digit(byte_q)) begin
        mode_d = MODE_NUM;
        acc_d  = NUM_W'(byte_q[3:0]);
      end else if (is_alpha(byte_q) || (byte_q == 8'h5F)) begin
        mode_d = MODE_WORD;
        we     = 1'b1;
        waddr  = '0;
        len_d  = LEN_W'(1);
      end else begin
        emit     = 1'b1;
        emit_res = mk_res(KIND_ERR, byte_q, 8'h00, '0, 1'b1);
      end
    end

    if (do_clear) begin
      mode_d = MODE_IDLE;
      acc_d  = '0;
      len_d  = '0;
      pend_d = 8'h00;
    end
  end

  // Two-deep result staging: a new result parks in the hold register so that
  // the one before it can leave knowing it was not the last of its request.
  assign load_out     = hold_valid_q && (emit || cmd_i.finish);
  assign hold_valid_d = emit ? 1'b1 : (cmd_i.finish ? 1'b0 : hold_valid_q);
  assign out_valid_d  = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      acc_q        <= '0;
      len_q        <= '0;
      pend_q       <= 8'h00;
      idx_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      acc_q        <= acc_d;
      len_q        <= len_d;
      pend_q       <= pend_d;
      idx_q        <= idx_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= source_byte_i;
      eos_q  <= end_of_source_i;
    end
    if (we && (waddr < ADDR_W'(3))) begin
      shadow_q[waddr[1:0]] <= byte_q;
    end
    if (emit) begin
      hold_res_q <= emit_res;
    end
    if (load_out) begin
      out_res_q  <= hold_res_q;
      out_step_q <= cmd_i.finish;
    end
  end

  always_comb begin
    st_o           = '0;
    st_o.mode      = mode_q;
    st_o.cont      = cont;
    st_o.eos       = eos_q;
    st_o.word_run  = (mode_q == MODE_WORD) && (len_q != '0) && !kw_hit;
    st_o.word_none = (mode_q == MODE_WORD) && (len_q == '0);
    st_o.word_last = word_last;
    st_o.can_emit  = can_emit;
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = out_res_q.kind;
  assign first_char_o  = out_res_q.first;
  assign second_char_o = out_res_q.second;
  assign number_o      = out_res_q.number;
  assign token_done_o  = out_res_q.done;
  assign step_done_o   = out_step_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_WORD_LEN))
    else $error("word length beyond store depth");

  a_word_emit_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.word_emit |-> (mode_q == MODE_WORD) && (len_q != '0))
    else $error("identifier character emitted without a pending word");

  a_finish_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && can_emit) |=> !hold_valid_q)
    else $error("staged result left behind after request end");

endmodule

@@ hw/rtl/stlex_ctrl.sv @@
module stlex_ctrl import stlex_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EVAL   = 6'b000010,
    ST_FLUSH  = 6'b000100,
    ST_WORD   = 6'b001000,
    ST_START  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   post_q, post_d;
  state_e after_flush;

  // A flush either precedes the new token or closes the source.
  assign after_flush = post_q ? ST_FINISH : ST_START;

  always_comb begin
    state_d    = state_q;
    post_d     = post_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!st_i.cont) begin
          post_d  = 1'b0;
          state_d = ST_FLUSH;
        end else if (st_i.can_emit) begin
          cmd_o.cont = 1'b1;
          post_d     = 1'b1;
          state_d    = st_i.eos ? ST_FLUSH : ST_FINISH;
        end
      end
      ST_FLUSH: begin
        if ((st_i.mode == MODE_IDLE) || st_i.word_none) begin
          cmd_o.clear = 1'b1;
          state_d     = after_flush;
        end else if (st_i.word_run) begin
          cmd_o.rd0 = 1'b1;
          state_d   = ST_WORD;
        end else if (st_i.can_emit) begin
          cmd_o.flush_tok = 1'b1;
          state_d         = after_flush;
        end
      end
      ST_WORD: begin
        if (st_i.can_emit) begin
          cmd_o.word_emit = 1'b1;
          if (st_i.word_last) begin
            state_d = after_flush;
          end
        end
      end
      ST_START: begin
        if (st_i.can_emit) begin
          cmd_o.start = 1'b1;
          post_d      = 1'b1;
          state_d     = st_i.eos ? ST_FLUSH : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st_i.can_emit) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      post_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      post_q  <= post_d;
    end
  end

  a_start_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> (st_i.mode == MODE_IDLE))
    else $error("new token opened over a pending one");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.finish && (st_i.mode != MODE_IDLE)) |-> !post_q || !st_i.eos)
    else $error("source ended with a token still pending");

  a_word_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd0 |=> (state_q == ST_WORD))
    else $error("word read started outside the character run");

endmodule

@@ sim/source_text_lexer_tb.sv @@
`timescale 1ns / 100ps

// Testbench for the byte-serial lexer. Source text goes in one request per
// byte. A predictor inside this module tracks the lexer state and queues the
// token results that each accepted request must produce. A checking process
// compares every accepted result against the oldest queued token.
module source_text_lexer_tb import stlex_pkg::*;;

  // Length of a receiver hold-off, in clock cycles, when a test asks for one.
  localparam int HOLD_OFF_CYCLES = 200;
  // Quiet cycles after the last expected token.
  localparam int TAIL_CYCLES     = 40;

  // Character classes as the lexer sees them. Letters and the underscore
  // share a class because either one may open a word.
  typedef enum logic [2:0] {
    CC_SEP,
    CC_SYM,
    CC_OP,
    CC_DIGIT,
    CC_WORD,
    CC_BAD
  } char_class_e;

  // One expected result: the token fields plus the end-of-request marker.
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       first;
    logic [7:0]       second;
    logic [NUM_W-1:0] number;
    logic             tok_done;
    logic             step_done;
  } token_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             in_ready_o;
  logic [7:0]       source_byte_i   = 8'h00;
  logic             end_of_source_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic [2:0]       token_kind_o;
  logic [7:0]       first_char_o;
  logic [7:0]       second_char_o;
  logic [NUM_W-1:0] number_o;
  logic             token_done_o;
  logic             step_done_o;

  // Tokens still owed by the lexer, oldest first.
  token_t expected_tokens[$];
  // Tokens caused by the request being predicted right now.
  token_t step_tokens[$];
  // Source text staged by a test before it is sent.
  logic [7:0] text_bytes[$];

  int error_count   = 0;
  // When set, neither side idles at random.
  bit steady_flow   = 1'b0;
  // A test bumps this to make the receiver hold off once.
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // Predictor state: scan mode, literal value, word buffer, held operator.
  mode_e            lex_mode;
  logic [NUM_W-1:0] lit_value;
  logic [7:0]       word_chars [MAX_WORD_LEN];
  int               word_len;
  logic [7:0]       held_op;

  // Keywords, type names and words that just miss them.
  string word_pool [12] = '{"var", "i64", "i32", "i16", "i8", "va", "vars", "i6",
                            "i128", "I8", "_var", "i640"};

  source_text_lexer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .source_byte_i   (source_byte_i),
    .end_of_source_i (end_of_source_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .token_kind_o    (token_kind_o),
    .first_char_o    (first_char_o),
    .second_char_o   (second_char_o),
    .number_o        (number_o),
    .token_done_o    (token_done_o),
    .step_done_o     (step_done_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic char_class_e classify(input logic [7:0] c);
    if (c == " " || c == 8'h0A || c == 8'h09) return CC_SEP;
    if (c >= "0" && c <= "9") return CC_DIGIT;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") return CC_WORD;
    case (c)
      "{", "}", ":", ";", "#", "(", ")", "[", "]": return CC_SYM;
      "+", "-", "*", "/", "%", "<", ">", "^", "!", "=", "~", "|", "&", ",", ".", "?":
        return CC_OP;
      default: return CC_BAD;
    endcase
  endfunction

  // True when the byte completes a two-character operator with the held one.
  function automatic logic pairs_with(input logic [7:0] held, input logic [7:0] c);
    if ((held == "&" || held == "|") && c == held) return 1'b1;
    if (c != "=") return 1'b0;
    case (held)
      "+", "-", "*", "/", "%", "!", "=", "<", ">": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit(input kind_e kind, input logic [7:0] c1, input logic [7:0] c2,
                               input logic [NUM_W-1:0] num, input logic tok_done);
    token_t t;
    t.kind      = kind;
    t.first     = c1;
    t.second    = c2;
    t.number    = num;
    t.tok_done  = tok_done;
    t.step_done = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void reset_lexer_model();
    lex_mode  = MODE_IDLE;
    lit_value = '0;
    word_len  = 0;
    held_op   = 8'h00;
    foreach (word_chars[i]) word_chars[i] = 8'h00;
  endfunction

  // A finished word is a keyword, a type name or a run of identifier
  // characters. A word that overflowed the buffer has a length of zero here
  // and produces nothing.
  function automatic void flush_word_tokens();
    logic [23:0] head;
    head = {word_chars[0], word_chars[1], word_chars[2]};
    if (word_len == 0) return;
    if (word_len == 3 && head == "var")
      emit(KIND_VAR, 8'h00, 8'h00, '0, 1'b1);
    else if (word_len == 3 && head == "i64")
      emit(KIND_TYPE, 8'h00, 8'h00, TYPE_I64, 1'b1);
    else if (word_len == 3 && head == "i32")
      emit(KIND_TYPE, 8'h00, 8'h00, TYPE_I32, 1'b1);
    else if (word_len == 3 && head == "i16")
      emit(KIND_TYPE, 8'h00, 8'h00, TYPE_I16, 1'b1);
    else if (word_len == 2 && head[23:8] == "i8")
      emit(KIND_TYPE, 8'h00, 8'h00, TYPE_I8, 1'b1);
    else
      for (int i = 0; i < word_len; i++)
        emit(KIND_IDENT, word_chars[i], 8'h00, '0, i == word_len - 1);
  endfunction

  function automatic void flush_pending();
    case (lex_mode)
      MODE_NUM:  emit(KIND_INT, 8'h00, 8'h00, lit_value, 1'b1);
      MODE_WORD: flush_word_tokens();
      MODE_OP:   emit(KIND_OP, held_op, 8'h00, '0, 1'b1);
      default: ;
    endcase
    lex_mode  = MODE_IDLE;
    lit_value = '0;
    word_len  = 0;
    held_op   = 8'h00;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    case (classify(c))
      CC_SEP: ;
      CC_SYM: emit(KIND_SYM, c, 8'h00, '0, 1'b1);
      CC_OP: begin
        lex_mode = MODE_OP;
        held_op  = c;
      end
      CC_DIGIT: begin
        lex_mode  = MODE_NUM;
        lit_value = NUM_W'(c - 8'h30);
      end
      CC_WORD: begin
        lex_mode      = MODE_WORD;
        word_chars[0] = c;
        word_len      = 1;
      end
      default: emit(KIND_ERR, c, 8'h00, '0, 1'b1);
    endcase
  endfunction

  // Works out what one accepted request produces and queues it.
  function automatic void predict_request(input logic [7:0] c, input logic last);
    longint unsigned grown;
    char_class_e     cc;
    step_tokens.delete();
    cc = classify(c);
    case (lex_mode)
      MODE_OP: begin
        if (pairs_with(held_op, c)) begin
          emit(KIND_OP, held_op, c, '0, 1'b1);
          lex_mode = MODE_IDLE;
          held_op  = 8'h00;
        end else begin
          flush_pending();
          open_token(c);
        end
      end
      MODE_NUM: begin
        if (cc == CC_DIGIT) begin
          // Decimal accumulate, clamped at the largest 31-bit value.
          grown     = 64'(lit_value) * 64'd10 + 64'(c - 8'h30);
          lit_value = (grown > 64'(NUM_LIMIT)) ? NUM_LIMIT : grown[NUM_W-1:0];
        end else begin
          flush_pending();
          open_token(c);
        end
      end
      MODE_WORD: begin
        if (cc == CC_DIGIT || cc == CC_WORD) begin
          // A zero length in word mode means an over-long word is being
          // swallowed; a full buffer turns the next character into an error.
          if (word_len == 0) begin
          end else if (word_len < MAX_WORD_LEN) begin
            word_chars[word_len] = c;
            word_len++;
          end else begin
            emit(KIND_ERR, c, 8'h00, '0, 1'b1);
            word_len = 0;
          end
        end else begin
          flush_pending();
          open_token(c);
        end
      end
      default: open_token(c);
    endcase
    if (last) flush_pending();
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].step_done = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] word_start_char();
    int pick;
    pick = $urandom_range(52);
    if (pick < 26) return 8'(pick) + "a";
    if (pick < 52) return 8'(pick - 26) + "A";
    return "_";
  endfunction

  function automatic logic [7:0] word_char();
    int pick;
    pick = $urandom_range(62);
    if (pick < 62) return (pick < 52) ? word_start_char() : 8'(pick - 52) + "0";
    return "_";
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endfunction

  function automatic void push_word(input int len);
    text_bytes.push_back(word_start_char());
    repeat (len - 1) text_bytes.push_back(word_char());
  endfunction

  // Appends one token-shaped fragment, most of them well formed, some of them
  // noise. About half the fragments run straight into the next one so that
  // tokens also end on the byte that opens the following token.
  function automatic void add_fragment();
    string      op_chars;
    string      sym_chars;
    string      sep_chars;
    logic [7:0] op;
    int         pick;
    op_chars  = "+-*/%<>^!=~|&,.?";
    sym_chars = "{}:;#()[]";
    sep_chars = " \n\t";
    pick = $urandom_range(99);
    if (pick < 24) begin
      push_word($urandom_range(8, 1));
    end else if (pick < 34) begin
      push_text(word_pool[$urandom_range(11)]);
    end else if (pick < 50) begin
      // Mostly short literals; now and then one long enough to saturate.
      repeat (($urandom_range(8) == 0) ? $urandom_range(12, 10) : $urandom_range(5, 1))
        text_bytes.push_back(8'($urandom_range(9)) + "0");
    end else if (pick < 68) begin
      op = op_chars[$urandom_range(op_chars.len() - 1)];
      text_bytes.push_back(op);
      if ($urandom_range(1) == 1)
        text_bytes.push_back(((op == "&" || op == "|") && $urandom_range(1) == 1) ? op : "=");
    end else if (pick < 78) begin
      text_bytes.push_back(sym_chars[$urandom_range(sym_chars.len() - 1)]);
    end else begin
      text_bytes.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 55)
      text_bytes.push_back(sep_chars[$urandom_range(sep_chars.len() - 1)]);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one request and waits for its handshake. Valid stays up between
  // back-to-back requests; it only drops for an idle gap or a release.
  task automatic send_byte(input logic [7:0] value, input logic last);
    if (!steady_flow && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    source_byte_i   <= value;
    end_of_source_i <= last;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    predict_request(value, last);
  endtask

  // Sends the staged text; end of source optionally rides on the last byte.
  task automatic send_queued(input bit eos_last);
    foreach (text_bytes[i])
      send_byte(text_bytes[i], eos_last && (i == text_bytes.size() - 1));
    text_bytes.delete();
  endtask

  task automatic send_text(input string s, input bit eos_last);
    text_bytes.delete();
    push_text(s);
    send_queued(eos_last);
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    release_input();
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Symbols, both two-character operator forms, an operator that fails to
  // pair, unknown bytes at both ends of the byte range, an operator still
  // held at end of source, the keyword and all four type names.
  task automatic test_directed();
    send_text("{+=&&|?", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("!", 1'b1);
    send_text("var i64 i32 i16 i8", 1'b1);
  endtask

  // Words just under, at and over the buffer size. The full-size word is
  // closed by a symbol, which gives the largest burst for a single request.
  task automatic test_long_words();
    int lengths [5] = '{31, 32, 33, 36, MAX_WORD_LEN + 1};
    foreach (lengths[k]) begin
      text_bytes.delete();
      push_word(lengths[k]);
      case (k % 3)
        0: text_bytes.push_back(" ");
        1: text_bytes.push_back("(");
        default: ;
      endcase
      send_queued(k % 3 == 2);
    end
  endtask

  // The receiver stops taking results for a long stretch while requests keep
  // coming, so the lexer backs up and stalls its request side.
  task automatic test_output_hold_off();
    hold_requests++;
    repeat (8) begin
      text_bytes.delete();
      push_word($urandom_range(6, 4));
      text_bytes.push_back(" ");
      send_queued(1'b0);
    end
  endtask

  // The sender stops until every owed token has come back, then resumes.
  task automatic test_drain_pause();
    send_text("count_1 = 42;", 1'b0);
    wait_for_drain();
    send_text("x", 1'b1);
  endtask

  // Random source text. The first stretch runs with no idling on either side.
  task automatic test_random_text();
    int sent;
    sent        = 0;
    steady_flow = 1'b1;
    while (sent < 90) begin
      if (sent >= 45) steady_flow = 1'b0;
      text_bytes.delete();
      add_fragment();
      sent += text_bytes.size();
      send_queued($urandom_range(5) == 0);
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Ready drops with odds of about one in six, except while a hold-off runs or
  // the steady stretch is on. The hold-off length is counted down here.
  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (steady_flow) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 17);
    end
  end

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Values read here are the ones present just before the edge, so each
  // accepted result is compared with exactly what the handshake moved.
  always @(posedge clk_i) begin : result_check
    token_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_tokens.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual kind %0d first %0h",
                 $time, token_kind_o, first_char_o);
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", want.kind, token_kind_o);
        check_field("first_char", want.first, first_char_o);
        check_field("second_char", want.second, second_char_o);
        check_field("number", want.number, number_o);
        check_field("token_done", want.tok_done, token_done_o);
        check_field("step_done", want.step_done, step_done_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_lexer_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_words();
    test_output_hold_off();
    test_drain_pause();
    test_random_text();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_tokens.size() == 0) begin
      $display("PASS source_text_lexer");
    end else begin
      $display("FAIL source_text_lexer");
    end
    $finish;
  end

  // Watchdog, many times the slowest legal run.
  initial begin
    #1000000;
    $display("FAIL source_text_lexer");
    $finish;
  end

endmodule
